// ===== rtl/core/grs_pkg.sv =====
// shared types and constants for the group reverse stream block
package grs_pkg;

  // payload and configuration widths
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned CFG_W         = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd1;

  // default depth of the hold buffer
  localparam int unsigned DEF_MAX_GROUP = 16;

  // controller phases
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } grs_state_e;

  // status of the output register
  typedef struct packed {
    logic valid;
    logic group_last;
    logic list_end;
  } grs_out_t;

endpackage

// ===== rtl/core/grs_mem.sv =====
// hold buffer: one write port, one read port with registered read data
module grs_mem #(
  parameter int unsigned MAX_GROUP = grs_pkg::DEF_MAX_GROUP,
  localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [grs_pkg::VALUE_W-1:0]  wr_data_i,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [grs_pkg::VALUE_W-1:0]  rd_data_o
);

  logic [grs_pkg::VALUE_W-1:0] mem_q [MAX_GROUP];
  logic [grs_pkg::VALUE_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/grs_ctrl.sv =====
// fill and drain sequencer for the hold buffer
module grs_ctrl #(
  parameter int unsigned MAX_GROUP = grs_pkg::DEF_MAX_GROUP,
  localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
  localparam int unsigned CW = $clog2(MAX_GROUP + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [grs_pkg::CFG_W-1:0]     group_size_i,
  input  logic                          in_valid_i,
  input  logic                          in_last_i,
  output logic                          in_ready_o,
  input  logic                          out_ready_i,
  output grs_pkg::grs_out_t             out_o,
  output logic                          wr_en_o,
  output logic [AW-1:0]                 wr_addr_o,
  output logic                          rd_en_o,
  output logic [AW-1:0]                 rd_addr_o
);

  localparam int unsigned EW = (CW > grs_pkg::CFG_W) ? CW : grs_pkg::CFG_W;
  localparam logic [EW-1:0] MAX_EXT = EW'(MAX_GROUP);

  grs_pkg::grs_state_e state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic                end_q, end_d;
  grs_pkg::grs_out_t   out_q, out_d;

  logic [EW-1:0] size_ext;
  logic [EW-1:0] eff_size;
  logic [EW-1:0] held_next;
  logic          accept;
  logic          close;
  logic          issue;

  // effective group size: zero acts as one, saturates at buffer depth
  always_comb begin
    size_ext = EW'(group_size_i);
    if (size_ext == '0) begin
      eff_size = EW'(1);
    end else if (size_ext > MAX_EXT) begin
      eff_size = MAX_EXT;
    end else begin
      eff_size = size_ext;
    end
  end

  // handshake and buffer port control
  assign in_ready_o = (state_q == grs_pkg::ST_FILL);
  assign accept     = in_valid_i && in_ready_o;
  assign held_next  = EW'(count_q) + EW'(1);
  assign close      = accept && ((held_next >= eff_size) || in_last_i);
  assign issue      = (state_q == grs_pkg::ST_DRAIN) && (!out_q.valid || out_ready_i);

  assign wr_en_o   = accept;
  assign wr_addr_o = count_q[AW-1:0];
  assign rd_en_o   = issue;
  assign rd_addr_o = rd_ptr_q;
  assign out_o     = out_q;

  // next state and output register
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    end_d    = end_q;
    out_d    = out_q;
    if (out_ready_i) begin
      out_d.valid = 1'b0;
    end
    unique case (state_q)
      grs_pkg::ST_FILL: begin
        if (close) begin
          count_d  = '0;
          rd_ptr_d = count_q[AW-1:0];
          end_d    = in_last_i;
          state_d  = grs_pkg::ST_DRAIN;
        end else if (accept) begin
          count_d = count_q + CW'(1);
        end
      end
      grs_pkg::ST_DRAIN: begin
        if (issue) begin
          out_d.valid      = 1'b1;
          out_d.group_last = (rd_ptr_q == '0);
          out_d.list_end   = (rd_ptr_q == '0) && end_q;
          rd_ptr_d         = rd_ptr_q - AW'(1);
          if (rd_ptr_q == '0) begin
            state_d = grs_pkg::ST_FILL;
          end
        end
      end
      default: begin
        state_d = grs_pkg::ST_FILL;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= grs_pkg::ST_FILL;
      count_q  <= '0;
      rd_ptr_q <= '0;
      end_q    <= 1'b0;
      out_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      end_q    <= end_d;
      out_q    <= out_d;
    end
  end

endmodule

// ===== rtl/core/group_reverse_stream.sv =====
// top level of the group reverse stream block
//
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+---------------------------------------
// s_axis   | in        | tvalid / tready       | tdata = value, tlast = list_end
// m_axis   | out       | tvalid / tready       | tdata = out_value, tuser = group_last,
//          |           |                       | tlast = out_list_end
// cfg      | in        | cfg_we_i              | cfg_wdata_i = group_size
//
// a group of n values is taken at one transfer per cycle, then read back
// newest first from the hold buffer while the input stalls; reads use the
// single read port of the buffer and wait while the output is stalled
// the output register decouples the sides; the next group starts filling
// while the last value of the previous one still waits
// reset clears control state only; no clearing pass over the buffer
module group_reverse_stream #(
  parameter int unsigned MAX_GROUP = grs_pkg::DEF_MAX_GROUP
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [grs_pkg::CFG_W-1:0]    cfg_wdata_i,    // group_size
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [grs_pkg::VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
  input  logic                         s_axis_tlast,   // list_end
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [grs_pkg::VALUE_W-1:0]  m_axis_tdata,   // [31:0] out_value
  output logic [0:0]                   m_axis_tuser,   // [0] group_last
  output logic                         m_axis_tlast    // out_list_end
);

  localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [grs_pkg::CFG_W-1:0] group_size_q;
  grs_pkg::grs_out_t         out_st;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;

  // group size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= grs_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      group_size_q <= cfg_wdata_i;
    end
  end

  // sequencer
  grs_ctrl #(
    .MAX_GROUP (MAX_GROUP)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .group_size_i (group_size_q),
    .in_valid_i   (s_axis_tvalid),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_ready_i  (m_axis_tready),
    .out_o        (out_st),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr)
  );

  // hold buffer
  grs_mem #(
    .MAX_GROUP (MAX_GROUP)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (m_axis_tdata)
  );

  // output status
  assign m_axis_tvalid   = out_st.valid;
  assign m_axis_tuser[0] = out_st.group_last;
  assign m_axis_tlast    = out_st.list_end;

endmodule

// ===== rtl/core/grs_checker.sv =====
// port level checks for the group reverse stream block
module grs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         s_axis_tlast,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [grs_pkg::VALUE_W-1:0]  m_axis_tdata,
  input logic [0:0]                   m_axis_tuser,
  input logic                         m_axis_tlast
);

  // stalled output transfer holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // end of list always closes a group
  a_end_is_group_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("list end without group end");

  // a list end transfer on the input starts a drain
  a_end_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still ready after list end");

  // new output only comes out of a drain, never while filling
  a_out_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output appeared while filling");

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
